[rtl/serial_image_loader_unit_macros.svh]
// ---------------------------------------------------------------------------
// serial_image_loader_unit_macros.svh
// Assertion macros for the serial image loader. Clock clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef SERIAL_IMAGE_LOADER_UNIT_MACROS_SVH
`define SERIAL_IMAGE_LOADER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every edge outside reset
`define SIL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// trig at one edge implies expr at the next edge
`define SIL_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`else

`define SIL_ASSERT_ALWAYS(label, expr, msg)
`define SIL_ASSERT_NEXT(label, trig, expr, msg)

`endif

`endif

[rtl/sil_pkg.sv]
// ---------------------------------------------------------------------------
// sil_pkg
// Types and constants of the serial image loader.
// ---------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned REG_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [REG_W-1:0] LOAD_BASE_RESET = 32'h0008_0000;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_BASE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_HIGH = 2'd2;

  typedef enum logic [2:0] {
    PHASE_HEADER  = 3'b001,
    PHASE_PAYLOAD = 3'b010,
    PHASE_DONE    = 3'b100
  } phase_t;

endpackage

[rtl/serial_image_loader_unit.sv]
// ---------------------------------------------------------------------------
// serial_image_loader_unit
// Length-prefixed byte loader: echo, header decode, protected memory writes.
// ---------------------------------------------------------------------------
// One received byte in, one result out, one transfer per clock sustained.
// Each accepted byte is decoded combinationally against the loader state
// and lands in the output register; the input side keeps taking bytes as
// long as that register is empty or is being drained in the same cycle, so
// the only thing that holds the input back is out_stall. The first four
// bytes give a little-endian payload length; the next "length" bytes come
// out as memory writes from load_base upward, with writes inside
// [protect_low, protect_high] suppressed. The last byte (or a zero length)
// raises finished; jump_request says to start at load_base. Later bytes
// produce an all-zero result. Configure only while idle.
// ---------------------------------------------------------------------------
`include "serial_image_loader_unit_macros.svh"

module serial_image_loader_unit #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [sil_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sil_pkg::REG_W-1:0]         cfg_data,
  // byte input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              echo_valid,
  output logic [7:0]                        echo_byte,
  output logic                              mem_write,
  output logic [31:0]                       mem_address,
  output logic [7:0]                        mem_data,
  output logic                              finished,
  output logic                              jump_request
);

  // width used for address compares: wide enough for both the address and
  // the 32-bit window registers
  localparam int unsigned CMP_W = (ADDRESS_WIDTH > sil_pkg::REG_W) ?
                                  ADDRESS_WIDTH : sil_pkg::REG_W;

  // configuration registers
  logic [sil_pkg::REG_W-1:0] load_base;
  logic [sil_pkg::REG_W-1:0] protect_low;
  logic [sil_pkg::REG_W-1:0] protect_high;

  // loader state
  sil_pkg::phase_t           phase, phase_next;
  logic [1:0]                header_count, header_count_next;
  logic [31:0]               length_acc, length_acc_next;
  logic [31:0]               bytes_left, bytes_left_next;
  logic [ADDRESS_WIDTH-1:0]  next_address, next_address_next;

  // result computed for the byte on the input
  logic        echo_valid_next;
  logic [7:0]  echo_byte_next;
  logic        mem_write_next;
  logic [31:0] mem_address_next;
  logic [7:0]  mem_data_next;
  logic        finished_next;
  logic        jump_request_next;

  logic                      in_accept;
  logic [CMP_W-1:0]          addr_wide;
  logic [CMP_W-1:0]          base_wide;
  logic [CMP_W-1:0]          reset_base_wide;
  logic                      in_window;
  logic [31:0]               length_full;
  logic [31:0]               bytes_left_dec;

  // output register can take a new result when empty or draining now
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign addr_wide       = CMP_W'(next_address);
  assign base_wide       = CMP_W'(load_base);
  assign reset_base_wide = CMP_W'(sil_pkg::LOAD_BASE_RESET);
  assign in_window       = (addr_wide >= CMP_W'(protect_low)) &&
                           (addr_wide <= CMP_W'(protect_high));
  assign bytes_left_dec  = bytes_left - 32'd1;

  // header byte merged into the length, little-endian
  always_comb begin
    length_full = length_acc;
    case (header_count)
      2'd0:    length_full[7:0]   = length_acc[7:0]   | rx_byte;
      2'd1:    length_full[15:8]  = length_acc[15:8]  | rx_byte;
      2'd2:    length_full[23:16] = length_acc[23:16] | rx_byte;
      default: length_full[31:24] = length_acc[31:24] | rx_byte;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_acc_next   = length_acc;
    bytes_left_next   = bytes_left;
    next_address_next = next_address;

    echo_valid_next   = 1'b0;
    echo_byte_next    = 8'd0;
    mem_write_next    = 1'b0;
    mem_address_next  = 32'd0;
    mem_data_next     = 8'd0;
    finished_next     = 1'b0;
    jump_request_next = 1'b0;

    case (phase)
      sil_pkg::PHASE_HEADER: begin
        echo_valid_next   = 1'b1;
        echo_byte_next    = rx_byte;
        length_acc_next   = length_full;
        header_count_next = header_count + 2'd1;
        if (header_count == 2'd3) begin
          if (length_full == 32'd0) begin
            // empty image: done right away, no jump
            finished_next = 1'b1;
            phase_next    = sil_pkg::PHASE_DONE;
          end else begin
            bytes_left_next   = length_full;
            next_address_next = base_wide[ADDRESS_WIDTH-1:0];
            phase_next        = sil_pkg::PHASE_PAYLOAD;
          end
        end
      end
      sil_pkg::PHASE_PAYLOAD: begin
        echo_valid_next   = 1'b1;
        echo_byte_next    = rx_byte;
        // address and data go out even when the write is masked
        mem_write_next    = !in_window;
        mem_address_next  = addr_wide[31:0];
        mem_data_next     = rx_byte;
        next_address_next = next_address + 1'b1;
        bytes_left_next   = bytes_left_dec;
        if (bytes_left_dec == 32'd0) begin
          finished_next     = 1'b1;
          jump_request_next = 1'b1;
          phase_next        = sil_pkg::PHASE_DONE;
        end
      end
      default: begin
        // done: byte dropped, all-zero result
      end
    endcase
  end

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base    <= sil_pkg::LOAD_BASE_RESET;
      protect_low  <= '0;
      protect_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sil_pkg::REG_LOAD_BASE:    load_base    <= cfg_data;
        sil_pkg::REG_PROTECT_LOW:  protect_low  <= cfg_data;
        sil_pkg::REG_PROTECT_HIGH: protect_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // loader state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sil_pkg::PHASE_HEADER;
      header_count <= '0;
      length_acc   <= '0;
      bytes_left   <= '0;
      next_address <= reset_base_wide[ADDRESS_WIDTH-1:0];
    end else if (in_accept) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      length_acc   <= length_acc_next;
      bytes_left   <= bytes_left_next;
      next_address <= next_address_next;
    end
  end

  // output register: valid is control, the fields are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo_valid   <= echo_valid_next;
      echo_byte    <= echo_byte_next;
      mem_write    <= mem_write_next;
      mem_address  <= mem_address_next;
      mem_data     <= mem_data_next;
      finished     <= finished_next;
      jump_request <= jump_request_next;
    end
  end

  // a payload phase always has bytes still to come
  `SIL_ASSERT_ALWAYS(a_payload_nonempty,
    !(phase == sil_pkg::PHASE_PAYLOAD) || (bytes_left != 32'd0),
    "payload phase with no bytes left")

  // a byte taken after completion yields a silent result
  `SIL_ASSERT_NEXT(a_done_silent,
    in_accept && (phase == sil_pkg::PHASE_DONE),
    out_valid && !echo_valid && !mem_write && !finished,
    "byte after completion produced output")

  // a jump is only requested together with completion and an echo
  `SIL_ASSERT_ALWAYS(a_jump_with_finish,
    !(out_valid && jump_request) || (finished && echo_valid),
    "jump request without completion")

endmodule

[dv/serial_image_loader_checker.sv]
// ---------------------------------------------------------------------------
// serial_image_loader_checker
// Watches the configuration port and both channels of the image loader,
// predicts one result per accepted byte and compares every result transfer
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module serial_image_loader_checker #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sil_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sil_pkg::REG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            echo_valid,
  input  logic [7:0]                      echo_byte,
  input  logic                            mem_write,
  input  logic [31:0]                     mem_address,
  input  logic [7:0]                      mem_data,
  input  logic                            finished,
  input  logic                            jump_request,
  output int                              error_count,
  output int                              results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  mem_data;
    logic        finished;
    logic        jump_request;
  } loader_result_t;

  // shadow registers
  logic [sil_pkg::REG_W-1:0] base_reg;
  logic [sil_pkg::REG_W-1:0] prot_low_reg;
  logic [sil_pkg::REG_W-1:0] prot_high_reg;

  // loader state
  sil_pkg::phase_t          load_phase;
  logic [1:0]               header_count;
  logic [31:0]              length_acc;
  logic [31:0]              bytes_left;
  logic [ADDRESS_WIDTH-1:0] next_addr;

  loader_result_t due_results[$];

  function automatic loader_result_t decode_rx_byte(input logic [7:0] b);
    loader_result_t           r;
    logic [ADDRESS_WIDTH-1:0] a;
    logic                     guarded;
    r = '0;
    case (load_phase)
      sil_pkg::PHASE_HEADER: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = b;
        length_acc   = length_acc | (32'(b) << (8 * header_count));
        header_count = header_count + 2'd1;
        if (header_count == 2'd0) begin
          if (length_acc == 32'd0) begin
            r.finished = 1'b1;
            load_phase = sil_pkg::PHASE_DONE;
          end else begin
            // load base is latched on the last length byte
            bytes_left = length_acc;
            next_addr  = ADDRESS_WIDTH'(base_reg);
            load_phase = sil_pkg::PHASE_PAYLOAD;
          end
        end
      end
      sil_pkg::PHASE_PAYLOAD: begin
        a             = next_addr;
        guarded       = (a >= prot_low_reg) && (a <= prot_high_reg);
        r.echo_valid  = 1'b1;
        r.echo_byte   = b;
        r.mem_write   = !guarded;
        r.mem_address = 32'(a);
        r.mem_data    = b;
        next_addr     = a + 1'b1;
        bytes_left    = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          r.finished     = 1'b1;
          r.jump_request = 1'b1;
          load_phase     = sil_pkg::PHASE_DONE;
        end
      end
      default: ;  // done: byte dropped, all-zero result
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    loader_result_t want;
    if (rst) begin
      error_count   = 0;
      base_reg      = sil_pkg::LOAD_BASE_RESET;
      prot_low_reg  = '0;
      prot_high_reg = '0;
      load_phase    = sil_pkg::PHASE_HEADER;
      header_count  = '0;
      length_acc    = '0;
      bytes_left    = '0;
      next_addr     = ADDRESS_WIDTH'(sil_pkg::LOAD_BASE_RESET);
      due_results.delete();
    end else begin
      // compare before predicting: a byte taken at this edge shows up later
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no result pending");
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("echo_valid", 32'(want.echo_valid), 32'(echo_valid));
          check_field("echo_byte", 32'(want.echo_byte), 32'(echo_byte));
          check_field("mem_write", 32'(want.mem_write), 32'(mem_write));
          check_field("mem_address", want.mem_address, mem_address);
          check_field("mem_data", 32'(want.mem_data), 32'(mem_data));
          check_field("finished", 32'(want.finished), 32'(finished));
          check_field("jump_request", 32'(want.jump_request), 32'(jump_request));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          sil_pkg::REG_LOAD_BASE:    base_reg      = cfg_data;
          sil_pkg::REG_PROTECT_LOW:  prot_low_reg  = cfg_data;
          sil_pkg::REG_PROTECT_HIGH: prot_high_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_results.push_back(decode_rx_byte(rx_byte));
    end
    results_due = due_results.size();
  end

endmodule

[dv/serial_image_loader_unit_tb.sv]
// ---------------------------------------------------------------------------
// serial_image_loader_unit_tb
// Drives one complete boot-image load through the loader: a length header,
// a payload that wraps the top of the address space under a series of
// protect windows, and trailing bytes after completion. A checker module
// beside the block predicts and compares; this module makes the traffic,
// runs a watchdog and reports the verdict.
// ---------------------------------------------------------------------------
module serial_image_loader_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index the register file does not decode; writes to it must be ignored
  localparam logic [sil_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 500;  // cycles with no transfer
  localparam int unsigned TAIL_CYCLES    = 16;   // quiet time after last result
  localparam int unsigned TRAILING_BYTES = 20;   // per batch, after completion

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [sil_pkg::CFG_INDEX_W-1:0] cfg_index = sil_pkg::REG_LOAD_BASE;
  logic [sil_pkg::REG_W-1:0]       cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic [7:0]                      rx_byte   = '0;
  logic                            out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic        mem_write;
  logic [31:0] mem_address;
  logic [7:0]  mem_data;
  logic        finished;
  logic        jump_request;

  int error_count;
  int results_due;

  // stimulus-side view of the load, used only to aim the protect windows
  logic [31:0] load_addr;     // address the next payload byte will get
  int unsigned to_load;       // payload bytes not yet sent
  bit          in_burst;      // sender runs back to back while set
  bit          out_burst;     // receiver never stalls while set
  int unsigned quiet_cycles = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  serial_image_loader_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_valid   (echo_valid),
    .echo_byte    (echo_byte),
    .mem_write    (mem_write),
    .mem_address  (mem_address),
    .mem_data     (mem_data),
    .finished     (finished),
    .jump_request (jump_request)
  );

  serial_image_loader_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_valid   (echo_valid),
    .echo_byte    (echo_byte),
    .mem_write    (mem_write),
    .mem_address  (mem_address),
    .mem_data     (mem_data),
    .finished     (finished),
    .jump_request (jump_request),
    .error_count  (error_count),
    .results_due  (results_due)
  );

  // All tasks are entered and left at a falling edge, where every input
  // changes. Each signal gets at most one assignment per falling edge.

  // one register write; the write lands at the next rising edge
  task automatic write_reg(input logic [sil_pkg::CFG_INDEX_W-1:0] index,
                           input logic [sil_pkg::REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input logic [sil_pkg::REG_W-1:0] lo,
                            input logic [sil_pkg::REG_W-1:0] hi);
    write_reg(sil_pkg::REG_PROTECT_LOW, lo);
    write_reg(sil_pkg::REG_PROTECT_HIGH, hi);
  endtask

  // one byte transfer, preceded by a random gap unless in a burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_byte  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic send_payload(input logic [7:0] b);
    send_byte(b);
    load_addr = load_addr + 32'd1;
    to_load   = to_load - 1;
  endtask

  // stop sending and wait until every result has come out: the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  // Result sink: a fresh random stall before each result transfer, with
  // no-stall stretches switched on now and then.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    out_burst = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) out_burst = ($urandom_range(0, 3) == 0);
      hold = out_burst ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] image_len;
    logic [31:0] image_base;
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned wrap_at;
    int unsigned seg;

    in_burst = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Image of 1536..2303 bytes, placed so the payload wraps past the top
    // of the address space somewhere in its middle.
    image_len  = {16'h0000, 8'($urandom_range(6, 8)), 8'($urandom_range(0, 255))};
    wrap_at    = $urandom_range(600, 1400);
    image_base = 32'h0 - wrap_at;

    // ---- directed part ----
    // Register extremes while the header is still coming in; only the
    // base present at the last length byte counts. Start with an inverted
    // window (low above high), which protects nothing.
    write_reg(sil_pkg::REG_LOAD_BASE, 32'h0000_0000);
    set_window(32'hFFFF_FFFF, 32'h0000_0000);
    write_reg(REG_SPARE, $urandom());
    send_byte(image_len[7:0]);
    settle();
    write_reg(sil_pkg::REG_LOAD_BASE, 32'hFFFF_FFFF);
    send_byte(image_len[15:8]);
    send_byte(image_len[23:16]);
    settle();
    write_reg(sil_pkg::REG_LOAD_BASE, image_base);
    send_byte(image_len[31:24]);
    load_addr = image_base;
    to_load   = image_len;

    // byte extremes under the inverted window
    send_payload(8'h00);
    send_payload(8'hFF);

    // window over bytes 2..4 of the next six payload bytes: both inclusive edges and one past
    settle();
    set_window(load_addr + 32'd2, load_addr + 32'd4);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h01);
    send_payload(8'h80);

    // single-address window on the very next byte
    settle();
    set_window(load_addr, load_addr);
    send_payload(8'($urandom()));
    send_payload(8'($urandom()));

    // whole address space protected
    settle();
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
    send_payload(8'($urandom()));
    send_payload(8'($urandom()));

    // a base change mid-load must not move the addresses
    settle();
    write_reg(sil_pkg::REG_LOAD_BASE, $urandom());
    set_window(32'h0000_0000, 32'h0000_0000);
    send_payload(8'($urandom()));

    // ---- random part ----
    // Rest of the payload in segments, each under a freshly chosen window.
    while (to_load != 0) begin
      seg = $urandom_range(40, 300);
      if (seg > to_load) seg = to_load;
      settle();
      case ($urandom_range(0, 6))
        0: set_window(32'h0000_0000, 32'h0000_0000);
        1: set_window(32'h0000_0000, 32'hFFFF_FFFF);
        2: begin
          // inverted
          hi = $urandom_range(0, 32'hFFFF_0000);
          lo = hi + $urandom_range(1, 4000);
          set_window(lo, hi);
        end
        3: begin
          // starts inside the coming segment or just past its end
          lo = load_addr + $urandom_range(0, seg);
          hi = lo + $urandom_range(0, seg / 2);
          set_window(lo, hi);
        end
        4: set_window($urandom(), $urandom());
        5: set_window(32'hFFFF_FFFF - $urandom_range(0, 300), 32'hFFFF_FFFF);
        default: set_window(32'h0000_0000, $urandom_range(0, 300));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(sil_pkg::REG_LOAD_BASE, $urandom());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
      in_burst = ($urandom_range(0, 3) == 0);
      repeat (seg) send_payload(8'($urandom()));
    end

    // ---- after completion ----
    // Loader is done; further bytes give an all-zero result regardless of
    // the registers.
    in_burst = 1'b0;
    repeat (TRAILING_BYTES) send_byte(8'($urandom()));
    settle();
    write_reg(sil_pkg::REG_LOAD_BASE, 32'hFFFF_FFFF);
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
    in_burst = 1'b1;
    repeat (TRAILING_BYTES) send_byte(8'($urandom()));

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sil_pkg.sv
rtl/serial_image_loader_unit.sv
dv/serial_image_loader_checker.sv
dv/serial_image_loader_unit_tb.sv
